/* rtl/core/pfra_pkg.sv */
// Shared types and constants of the page frame reference count allocator.
`timescale 1ns / 1ps

package pfra_pkg;

  // Frame table geometry
  localparam int          FRAMES       = 8192;
  localparam int          IDX_W        = $clog2(FRAMES);
  localparam int          FRAME_SHIFT  = 12;
  localparam logic [31:0] BASE_ADDRESS = 32'h0010_0000;
  localparam logic [7:0]  RESERVED_CNT = 8'd100;
  localparam logic [7:0]  MAX_CNT      = 8'hFF;

  // Frame range bounds for init: page number plus one carry bit
  localparam int RANGE_W = 32 - FRAME_SHIFT + 1;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAMES - 1);

  typedef enum logic [1:0] {
    MODE_INIT  = 2'd0,
    MODE_ALLOC = 2'd1,
    MODE_FREE  = 2'd2,
    MODE_SHARE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    STAT_OK          = 3'd0,
    STAT_OOM         = 3'd1,
    STAT_NONEXIST    = 3'd2,
    STAT_ALREADY_FREE = 3'd3,
    STAT_LOW         = 3'd4,
    STAT_SATURATED   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_INIT_CALC,
    S_INIT_SUM,
    S_SCAN,
    S_LOCATE,
    S_MODIFY,
    S_FINISH
  } state_t;

  // Request to the count memory
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [7:0]       wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  // Answer of the count unit
  typedef struct packed {
    logic       hit;
    logic [7:0] value;
  } cu_res_t;

  // Finished result word handed to the output register
  typedef struct packed {
    logic        valid;
    logic [31:0] addr;
    status_t     status;
  } res_t;

endpackage

/* rtl/core/page_frame_refcount_allocator.sv */
// Top level of the page frame allocator with per-frame reference counts.
// Free and add reference: locate, modify and finish states from accept to result word,
// locate and finish only when the address is rejected; init: calc, sum, sweep, finish.
// Allocate: run time set by the one-entry-per-cycle downward scan of the count
// memory read port. One item at a time; a result word waits in the output register
// while the next item is taken. After rst a sweep writes the reserved count into
// every frame; no item is taken meanwhile.
`timescale 1ns / 1ps

module page_frame_refcount_allocator
  import pfra_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [31:0] page_address,
  input  logic [31:0] end_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result_address,
  output logic [2:0]  status
);

  logic ready;
  logic take;
  res_t res;

  pfra_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_valid && ready),
    .mode         (mode),
    .page_address (page_address),
    .end_address  (end_address),
    .take         (take),
    .ready        (ready),
    .res          (res)
  );

  assign in_stall = !ready;
  assign take     = res.valid && (!out_valid || !out_stall);

  // Hold the result word until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (take) begin
      result_address <= res.addr;
      status         <= res.status;
    end
  end

endmodule

/* rtl/core/pfra_count_mem.sv */
// Frame reference count memory: one write port, one registered read port.
`timescale 1ns / 1ps

module pfra_count_mem
  import pfra_pkg::*;
(
  input  logic       clk,
  input  mem_req_t   req,
  output logic [7:0] rd_data
);

  logic [7:0] mem [FRAMES];

  // Write the addressed count
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    rd_data <= mem[req.raddr];
  end

endmodule

/* rtl/core/pfra_count_unit.sv */
// Shared count unit: zero/full test and set, increment or decrement of one count, or the reserved count for init.
`timescale 1ns / 1ps

module pfra_count_unit
  import pfra_pkg::*;
(
  input  mode_t      op,
  input  logic [7:0] count,
  output cu_res_t    res
);

  // Test the count and form its new value for the operation
  always_comb begin
    unique case (op)
      MODE_ALLOC: begin
        res.hit   = (count == 8'd0);
        res.value = 8'd1;
      end
      MODE_FREE: begin
        res.hit   = (count == 8'd0);
        res.value = count - 8'd1;
      end
      MODE_SHARE: begin
        res.hit   = (count == MAX_CNT);
        res.value = count + 8'd1;
      end
      default: begin
        res.hit   = 1'b0;
        res.value = RESERVED_CNT;
      end
    endcase
  end

endmodule

/* rtl/core/pfra_seq.sv */
// Sequencer: sweeps, scans and updates the frame count table one entry a cycle.
`timescale 1ns / 1ps

module pfra_seq
  import pfra_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [1:0]  mode,
  input  logic [31:0] page_address,
  input  logic [31:0] end_address,
  input  logic        take,
  output logic        ready,
  output res_t        res
);

  state_t state, state_next;

  mode_t              mode_r;
  logic [31:0]        addr_r;
  logic [31:0]        end_r;
  logic [31:0]        top_of_memory;
  logic [RANGE_W-1:0] lo;
  logic [RANGE_W-1:0] hi;
  logic [RANGE_W-2:0] cnt;
  logic [IDX_W-1:0]   sweep_idx;
  logic               sweep_init;
  logic [IDX_W-1:0]   scan_idx;
  logic [IDX_W-1:0]   chk_idx;
  logic               chk_vld;
  logic [IDX_W-1:0]   idx_r;
  logic [31:0]        res_addr;
  status_t            res_status;

  mem_req_t   mem_req;
  logic [7:0] rd_data;
  mode_t      cu_op;
  cu_res_t    cu;

  logic [31:0]        start_off;
  logic [31:0]        span;
  logic [31:0]        off;
  logic [IDX_W-1:0]   off_idx;
  logic               addr_low;
  logic               addr_nonexist;
  logic               in_range;
  logic [RANGE_W-1:0] sweep_ext;
  logic               found;
  logic               exhausted;

  pfra_count_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  pfra_count_unit u_cu (
    .op    (cu_op),
    .count (rd_data),
    .res   (cu)
  );

  // Address arithmetic for init bounds and frame lookup
  assign start_off     = addr_r - BASE_ADDRESS;
  assign span          = end_r - addr_r;
  assign off           = start_off >> FRAME_SHIFT;
  assign off_idx       = off[IDX_W-1:0];
  assign addr_low      = (addr_r < BASE_ADDRESS);
  assign addr_nonexist = (addr_r >= top_of_memory) || (off >= 32'(FRAMES));

  // Sweep range test and scan outcome
  assign sweep_ext = RANGE_W'(sweep_idx);
  assign in_range  = (sweep_ext >= lo) && (sweep_ext < hi);
  assign cu_op     = (state == S_SWEEP) ? MODE_INIT : mode_r;
  assign found     = chk_vld && cu.hit;
  assign exhausted = chk_vld && !cu.hit && (chk_idx == '0);

  assign ready = (state == S_IDLE);

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  // Pick next state, memory request and result
  always_comb begin
    state_next    = state;
    mem_req.we    = 1'b0;
    mem_req.waddr = sweep_idx;
    mem_req.wdata = cu.value;
    mem_req.raddr = scan_idx;
    res.valid     = 1'b0;
    res.addr      = res_addr;
    res.status    = res_status;
    unique case (state)
      S_SWEEP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = sweep_idx;
        mem_req.wdata = in_range ? 8'd0 : cu.value;
        if (sweep_idx == LAST_IDX) begin
          state_next = sweep_init ? S_FINISH : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (mode_t'(mode))
            MODE_INIT:  state_next = S_INIT_CALC;
            MODE_ALLOC: state_next = S_SCAN;
            default:    state_next = S_LOCATE;
          endcase
        end
      end
      S_INIT_CALC: begin
        state_next = S_INIT_SUM;
      end
      S_INIT_SUM: begin
        state_next = S_SWEEP;
      end
      S_SCAN: begin
        mem_req.raddr = scan_idx;
        if (found) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = chk_idx;
          mem_req.wdata = cu.value;
          state_next    = S_FINISH;
        end else if (exhausted) begin
          state_next = S_FINISH;
        end
      end
      S_LOCATE: begin
        mem_req.raddr = off_idx;
        state_next    = (addr_low || addr_nonexist) ? S_FINISH : S_MODIFY;
      end
      S_MODIFY: begin
        mem_req.we    = !cu.hit;
        mem_req.waddr = idx_r;
        mem_req.wdata = cu.value;
        state_next    = S_FINISH;
      end
      S_FINISH: begin
        res.valid = 1'b1;
        if (take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Capture the item and advance the working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      top_of_memory <= '0;
      lo            <= '0;
      hi            <= '0;
      sweep_idx     <= '0;
      sweep_init    <= 1'b0;
      chk_vld       <= 1'b0;
      mode_r        <= MODE_INIT;
    end else begin
      unique case (state)
        S_SWEEP: begin
          sweep_idx <= sweep_idx + IDX_W'(1);
        end
        S_IDLE: begin
          if (accept) begin
            mode_r     <= mode_t'(mode);
            addr_r     <= page_address;
            end_r      <= end_address;
            scan_idx   <= LAST_IDX;
            chk_vld    <= 1'b0;
            res_addr   <= '0;
            res_status <= STAT_OK;
          end
        end
        S_INIT_CALC: begin
          top_of_memory <= end_r;
          lo            <= {1'b0, off[RANGE_W-2:0]};
          cnt           <= (end_r > addr_r) ? span[31:FRAME_SHIFT] : '0;
        end
        S_INIT_SUM: begin
          hi         <= {1'b0, lo[RANGE_W-2:0]} + {1'b0, cnt};
          sweep_idx  <= '0;
          sweep_init <= 1'b1;
        end
        S_SCAN: begin
          scan_idx <= scan_idx - IDX_W'(1);
          chk_idx  <= scan_idx;
          chk_vld  <= 1'b1;
          if (found) begin
            res_addr <= BASE_ADDRESS + (32'(chk_idx) << FRAME_SHIFT);
          end else if (exhausted) begin
            res_status <= STAT_OOM;
          end
        end
        S_LOCATE: begin
          idx_r <= off_idx;
          if (addr_low) begin
            res_status <= STAT_LOW;
          end else if (addr_nonexist) begin
            res_status <= STAT_NONEXIST;
          end
        end
        S_MODIFY: begin
          if (cu.hit) begin
            res_status <= (mode_r == MODE_FREE) ? STAT_ALREADY_FREE : STAT_SATURATED;
          end
        end
        S_FINISH: begin
          sweep_init <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !mem_req.we)
    else $error("count table written while idle");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status != STAT_OK |-> res.addr == '0)
    else $error("failed item carries a nonzero address");

  a_sweep_step: assert property (@(posedge clk) disable iff (rst)
    !rst && state == S_SWEEP && sweep_idx != LAST_IDX
      |=> state == S_SWEEP && sweep_idx == $past(sweep_idx) + IDX_W'(1))
    else $error("sweep left early or skipped an entry");

  a_modify_after_locate: assert property (@(posedge clk) disable iff (rst)
    state == S_MODIFY |-> $past(state) == S_LOCATE)
    else $error("count update without a range check");
`endif

endmodule

/* tb/sv/page_frame_refcount_allocator_tb.sv */
// Self-checking testbench of the page frame reference count allocator.
`timescale 1ns / 1ps

module page_frame_refcount_allocator_tb;
  import pfra_pkg::*;

  // Longest legal quiet stretch is one table walk; allow several
  localparam int STALL_LIMIT = 6 * FRAMES;
  localparam int DRAIN_CYCLES = 64;

  typedef struct {
    logic [31:0] addr;
    status_t     stat;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  mode = MODE_ALLOC;
  logic [31:0] page_address = '0;
  logic [31:0] end_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] result_address;
  logic [2:0]  status;

  // Predicted allocator state
  logic [7:0]  frame_count [FRAMES];
  logic [31:0] mem_top;

  frame_result_t pending_results [$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          stall_left = 0;
  bit          idle_on = 1'b1;

  page_frame_refcount_allocator u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .page_address   (page_address),
    .end_address    (end_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_address (result_address),
    .status         (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] frame_addr(input int unsigned k, input logic [11:0] low);
    return BASE_ADDRESS + (k << FRAME_SHIFT) + 32'(low);
  endfunction

  // Highest frame with a zero count, -1 when none
  function automatic int top_free_frame();
    for (int k = FRAMES - 1; k >= 0; k--) begin
      if (frame_count[k] == 8'd0) return k;
    end
    return -1;
  endfunction

  // Range check for free and add reference
  function automatic status_t locate_frame_idx(input logic [31:0] a, output int unsigned idx);
    logic [31:0] off;
    idx = 0;
    off = (a - BASE_ADDRESS) >> FRAME_SHIFT;
    if (a < BASE_ADDRESS) return STAT_LOW;
    if (a >= mem_top) return STAT_NONEXIST;
    if (off >= FRAMES) return STAT_NONEXIST;
    idx = off;
    return STAT_OK;
  endfunction

  // Apply one word to the predicted state and return its result
  function automatic frame_result_t predict_word(input mode_t m, input logic [31:0] pa,
                                                 input logic [31:0] ea);
    frame_result_t   r;
    int              k;
    int unsigned     idx;
    longint unsigned first_idx, span, j;
    r.addr = '0;
    r.stat = STAT_OK;
    case (m)
      MODE_INIT: begin
        mem_top = ea;
        foreach (frame_count[i]) frame_count[i] = RESERVED_CNT;
        first_idx = 64'((pa - BASE_ADDRESS) >> FRAME_SHIFT);
        span = (ea > pa) ? 64'((ea - pa) >> FRAME_SHIFT) : 64'd0;
        for (j = first_idx; j < first_idx + span && j < FRAMES; j++) frame_count[j] = 8'd0;
      end
      MODE_ALLOC: begin
        k = top_free_frame();
        if (k >= 0) begin
          frame_count[k] = 8'd1;
          r.addr = frame_addr(k, 12'h000);
        end else begin
          r.stat = STAT_OOM;
        end
      end
      MODE_FREE: begin
        r.stat = locate_frame_idx(pa, idx);
        if (r.stat == STAT_OK) begin
          if (frame_count[idx] == 8'd0) r.stat = STAT_ALREADY_FREE;
          else frame_count[idx] = frame_count[idx] - 8'd1;
        end
      end
      default: begin
        r.stat = locate_frame_idx(pa, idx);
        if (r.stat == STAT_OK) begin
          if (frame_count[idx] == MAX_CNT) r.stat = STAT_SATURATED;
          else frame_count[idx] = frame_count[idx] + 8'd1;
        end
      end
    endcase
    return r;
  endfunction

  // Send one word, optionally after a gap, and record its expected result
  task automatic send_word(input mode_t m, input logic [31:0] pa, input logic [31:0] ea);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= m;
    page_address <= pa;
    end_address  <= ea;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_word(m, pa, ea));
  endtask

  // Mostly frames near the top of the table, where the free ones live
  function automatic logic [31:0] pick_frame_address();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 8) return frame_addr($urandom_range(FRAMES - 64, FRAMES - 1), 12'($urandom));
    if (sel == 8) return frame_addr($urandom_range(0, FRAMES - 1), 12'($urandom));
    return $urandom;
  endfunction

  // Output side stall bursts
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each result word with the oldest prediction
  always @(posedge clk) begin
    frame_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, actual addr %h status %0d",
                 $time, result_address, status);
        mismatches++;
      end else begin
        e = pending_results.pop_front();
        if (result_address !== e.addr) begin
          $display("%0t: result_address expected %h actual %h", $time, e.addr, result_address);
          mismatches++;
        end
        if (status !== e.stat) begin
          $display("%0t: status expected %0d actual %0d", $time, e.stat, status);
          mismatches++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Everything reserved and no top of memory right after reset
  task automatic test_reset_state();
    send_word(MODE_ALLOC, '0, '0);
    send_word(MODE_FREE, 32'h0000_0000, 32'hFFFF_FFFF);
    send_word(MODE_SHARE, BASE_ADDRESS, '0);
    send_word(MODE_FREE, 32'hFFFF_FFFF, '0);
  endtask

  // Basic allocate, free and share on a small top range
  task automatic test_alloc_free_share();
    send_word(MODE_INIT, frame_addr(FRAMES - 8, 12'h000), frame_addr(FRAMES, 12'h000));
    send_word(MODE_ALLOC, '0, '0);
    send_word(MODE_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(MODE_SHARE, frame_addr(FRAMES - 1, 12'hFFF), '0);
    send_word(MODE_FREE, frame_addr(FRAMES - 1, 12'h000), '0);
    send_word(MODE_FREE, frame_addr(FRAMES - 1, 12'h800), '0);
    send_word(MODE_FREE, frame_addr(FRAMES - 1, 12'h000), '0);
    send_word(MODE_SHARE, frame_addr(0, 12'h000), '0);
    send_word(MODE_FREE, frame_addr(1, 12'h000), '0);
    send_word(MODE_FREE, frame_addr(FRAMES, 12'h000), '0);
    send_word(MODE_FREE, BASE_ADDRESS - 32'd1, '0);
    send_word(MODE_SHARE, 32'h0000_0000, '0);
  endtask

  // Init corner cases: open top, start below base, empty and inverted ranges
  task automatic test_init_edges();
    send_word(MODE_INIT, frame_addr(FRAMES - 4, 12'h000), 32'hFFFF_FFFF);
    send_word(MODE_FREE, 32'hFFFF_F000, '0);
    send_word(MODE_SHARE, 32'hFFFF_FFFF, '0);
    send_word(MODE_ALLOC, '0, '0);
    send_word(MODE_INIT, 32'h0000_0000, 32'h0020_0000);
    send_word(MODE_ALLOC, '0, '0);
    send_word(MODE_INIT, frame_addr(100, 12'h000), frame_addr(100, 12'h000));
    send_word(MODE_INIT, frame_addr(200, 12'h000), frame_addr(100, 12'h000));
    send_word(MODE_INIT, BASE_ADDRESS, frame_addr(1, 12'h000));
    send_word(MODE_ALLOC, '0, '0);
    send_word(MODE_INIT, frame_addr(FRAMES - 3, 12'h7FF), frame_addr(FRAMES, 12'h3FF));
    send_word(MODE_ALLOC, '0, '0);
    send_word(MODE_INIT, BASE_ADDRESS, frame_addr(FRAMES, 12'h000));
    send_word(MODE_ALLOC, '0, '0);
  endtask

  // Drive one reserved frame up to the count limit and past it
  task automatic test_saturation();
    send_word(MODE_INIT, frame_addr(FRAMES - 4, 12'h000), frame_addr(FRAMES, 12'h000));
    repeat (156) send_word(MODE_SHARE, frame_addr(FRAMES - 20, 12'($urandom)), $urandom);
    send_word(MODE_FREE, frame_addr(FRAMES - 20, 12'h000), '0);
    send_word(MODE_SHARE, frame_addr(FRAMES - 20, 12'h000), '0);
  endtask

  // One init followed by a stream of mixed traffic
  task automatic run_epoch(input int n_words);
    int unsigned span, first_idx, pick;
    logic [31:0] start_a, end_a;
    pick      = $urandom_range(0, 19);
    span      = $urandom_range(1, 48);
    first_idx = FRAMES - span - $urandom_range(0, 8);
    start_a   = frame_addr(first_idx, ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'h000);
    end_a     = start_a + (span << FRAME_SHIFT) + 32'($urandom_range(0, 4095));
    if (pick < 2) begin
      start_a = $urandom;
      end_a   = $urandom;
    end else if (pick < 4) begin
      start_a = BASE_ADDRESS;
      end_a   = frame_addr(FRAMES, 12'h000);
    end else if (pick < 8) begin
      end_a = start_a + $urandom;
    end
    send_word(MODE_INIT, start_a, end_a);
    for (int n = 0; n < n_words; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        // Keep scans short; a failing allocate walks the whole table
        if (top_free_frame() >= FRAMES - 256 || $urandom_range(0, 39) == 0)
          send_word(MODE_ALLOC, $urandom, $urandom);
        else
          send_word(MODE_FREE, pick_frame_address(), $urandom);
      end else if (pick < 92) begin
        send_word(pick[0] ? MODE_FREE : MODE_SHARE, pick_frame_address(), $urandom);
      end else begin
        send_word($urandom_range(0, 1) ? MODE_FREE : MODE_SHARE, $urandom, $urandom);
      end
    end
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 15; p++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      run_epoch(40);
    end
  endtask

  task automatic test_quiet_tail();
    idle_on = 1'b0;
    run_epoch(25);
    run_epoch(25);
  endtask

  initial begin
    foreach (frame_count[i]) frame_count[i] = RESERVED_CNT;
    mem_top = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_alloc_free_share();
    test_init_edges();
    test_saturation();
    test_random_traffic();
    test_quiet_tail();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

/* files.f */
rtl/core/pfra_pkg.sv
rtl/core/pfra_count_mem.sv
rtl/core/pfra_count_unit.sv
rtl/core/pfra_seq.sv
rtl/core/page_frame_refcount_allocator.sv
tb/sv/page_frame_refcount_allocator_tb.sv
